>>> hw/rtl/three_level_priority_queue_top_assert.svh
// three_level_priority_queue_top_assert.svh
// Assertion macros for the priority queue RTL; they expect clk and rst_n in scope.
`ifndef THREE_LEVEL_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define THREE_LEVEL_PRIORITY_QUEUE_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising edge outside reset
`define TLPQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlpq: assertion failed");
// Next-cycle implication
`define TLPQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlpq: assertion failed");
`else
`define TLPQ_ASSERT_NOW(lbl, ante, cons)
`define TLPQ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> hw/rtl/tlpq_pkg.sv
// tlpq_pkg.sv
// Types and constants shared by the priority queue controller, datapath and top.
// No dependencies.
`timescale 1ns / 1ps

package tlpq_pkg;

    localparam int PRIO_W = 2;
    localparam int TAG_W  = 8;

    localparam logic [PRIO_W-1:0] PRIO_INVALID = 2'd3;
    localparam logic [PRIO_W-1:0] PRIO_LOW     = 2'd0;
    localparam logic              MODE_READ    = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        ST_SENT    = 3'd0,
        ST_READ    = 3'd1,
        ST_FULL    = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_BADPRIO = 3'd4
    } status_t;

    // Datapath operation for one cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_SCAN_CLR,
        OP_SCAN_STEP,
        OP_STORE,
        OP_STORE_FIRST,
        OP_APPEND,
        OP_PUSH_HEAD,
        OP_WALK_START,
        OP_WALK_ADV,
        OP_LINK1,
        OP_LINK2,
        OP_POP,
        OP_OUT_LOAD
    } op_t;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_STORE,
        S_APPEND,
        S_HEADCHK,
        S_WALK,
        S_WALK_WAIT,
        S_LINK1,
        S_LINK2,
        S_RESP
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        op_t     op;
        logic    rd_next;
        logic    res_load;
        status_t res_status;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic item_read;
        logic item_prio_bad;
        logic item_prio_zero;
        logic count_zero;
        logic count_full;
        logic scan_free;
        logic scan_last;
        logic prio_below;
        logic walk_at_tail;
        logic out_free;
    } stat_t;

endpackage

>>> hw/rtl/tlpq_ram.sv
// tlpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tlpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/tlpq_ctrl.sv
// tlpq_ctrl.sv
// Controller state machine of the priority queue: sequences scan, store, list walk.
// Depends on tlpq_pkg.
`timescale 1ns / 1ps

module tlpq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  tlpq_pkg::stat_t stat,
    output tlpq_pkg::cmd_t  cmd
);

    tlpq_pkg::state_t state_reg;
    tlpq_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tlpq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        cmd.op         = tlpq_pkg::OP_NONE;
        cmd.rd_next    = 1'b0;
        cmd.res_load   = 1'b0;
        cmd.res_status = tlpq_pkg::ST_SENT;

        unique case (state_reg)
            tlpq_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = tlpq_pkg::OP_LATCH;
                    state_next = tlpq_pkg::S_DECODE;
                end
            end

            tlpq_pkg::S_DECODE:
            begin
                priority if (stat.item_read)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = tlpq_pkg::S_RESP;
                    if (stat.count_zero)
                    begin
                        cmd.res_status = tlpq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        cmd.op         = tlpq_pkg::OP_POP;
                        cmd.res_status = tlpq_pkg::ST_READ;
                    end
                end
                else if (stat.count_full)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = tlpq_pkg::ST_FULL;
                    state_next     = tlpq_pkg::S_RESP;
                end
                else if (stat.item_prio_bad)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = tlpq_pkg::ST_BADPRIO;
                    state_next     = tlpq_pkg::S_RESP;
                end
                else
                begin
                    cmd.op     = tlpq_pkg::OP_SCAN_CLR;
                    state_next = tlpq_pkg::S_SCAN;
                end
            end

            // Look for the lowest free slot, one slot a cycle
            tlpq_pkg::S_SCAN:
            begin
                priority if (stat.scan_free)
                begin
                    cmd.op     = tlpq_pkg::OP_SCAN_STEP;
                    state_next = tlpq_pkg::S_STORE;
                end
                else if (stat.scan_last)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = tlpq_pkg::ST_FULL;
                    state_next     = tlpq_pkg::S_RESP;
                end
                else
                begin
                    cmd.op = tlpq_pkg::OP_SCAN_STEP;
                end
            end

            tlpq_pkg::S_STORE:
            begin
                priority if (stat.count_zero)
                begin
                    cmd.op         = tlpq_pkg::OP_STORE_FIRST;
                    cmd.res_load   = 1'b1;
                    cmd.res_status = tlpq_pkg::ST_SENT;
                    state_next     = tlpq_pkg::S_RESP;
                end
                else if (stat.item_prio_zero)
                begin
                    cmd.op     = tlpq_pkg::OP_STORE;
                    state_next = tlpq_pkg::S_APPEND;
                end
                else
                begin
                    cmd.op     = tlpq_pkg::OP_STORE;
                    state_next = tlpq_pkg::S_HEADCHK;
                end
            end

            tlpq_pkg::S_APPEND:
            begin
                cmd.op         = tlpq_pkg::OP_APPEND;
                cmd.res_load   = 1'b1;
                cmd.res_status = tlpq_pkg::ST_SENT;
                state_next     = tlpq_pkg::S_RESP;
            end

            tlpq_pkg::S_HEADCHK:
            begin
                if (stat.prio_below)
                begin
                    cmd.op         = tlpq_pkg::OP_PUSH_HEAD;
                    cmd.res_load   = 1'b1;
                    cmd.res_status = tlpq_pkg::ST_SENT;
                    state_next     = tlpq_pkg::S_RESP;
                end
                else
                begin
                    cmd.op     = tlpq_pkg::OP_WALK_START;
                    state_next = tlpq_pkg::S_WALK;
                end
            end

            // Stop at the tail, else fetch the successor
            tlpq_pkg::S_WALK:
            begin
                if (stat.walk_at_tail)
                begin
                    state_next = tlpq_pkg::S_LINK1;
                end
                else
                begin
                    cmd.rd_next = 1'b1;
                    state_next  = tlpq_pkg::S_WALK_WAIT;
                end
            end

            tlpq_pkg::S_WALK_WAIT:
            begin
                if (stat.prio_below)
                begin
                    state_next = tlpq_pkg::S_LINK1;
                end
                else
                begin
                    cmd.op     = tlpq_pkg::OP_WALK_ADV;
                    state_next = tlpq_pkg::S_WALK;
                end
            end

            tlpq_pkg::S_LINK1:
            begin
                cmd.op     = tlpq_pkg::OP_LINK1;
                state_next = tlpq_pkg::S_LINK2;
            end

            tlpq_pkg::S_LINK2:
            begin
                cmd.op         = tlpq_pkg::OP_LINK2;
                cmd.res_load   = 1'b1;
                cmd.res_status = tlpq_pkg::ST_SENT;
                state_next     = tlpq_pkg::S_RESP;
            end

            // Hand the result to the output register once it is free
            tlpq_pkg::S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = tlpq_pkg::OP_OUT_LOAD;
                    state_next = tlpq_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = tlpq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/tlpq_dp.sv
// tlpq_dp.sv
// Datapath of the priority queue: slot RAMs, used bits, list pointers, output register.
// Depends on tlpq_pkg, tlpq_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "three_level_priority_queue_top_assert.svh"

module tlpq_dp #(
    parameter int SLOTS      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tlpq_pkg::cmd_t                  cmd,
    output tlpq_pkg::stat_t                 stat,
    input  logic                            in_mode,
    input  logic [tlpq_pkg::PRIO_W-1:0]     in_priority_req,
    input  logic [tlpq_pkg::TAG_W-1:0]      in_producer_tag,
    input  logic [DATA_WIDTH-1:0]           in_payload,
    output logic                            out_valid,
    input  logic                            out_ready,
    output tlpq_pkg::status_t               out_status,
    output logic [$clog2(SLOTS+1)-1:0]      out_queued_count,
    output logic [tlpq_pkg::PRIO_W-1:0]     out_priority,
    output logic [tlpq_pkg::TAG_W-1:0]      out_producer_tag,
    output logic [DATA_WIDTH-1:0]           out_payload
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int PW = tlpq_pkg::PRIO_W;
    localparam int TW = tlpq_pkg::TAG_W;
    localparam int DW = TW + DATA_WIDTH;

    // Latched item
    logic                 item_read_reg, item_read_next;
    logic [PW-1:0]        item_prio_reg, item_prio_next;
    logic [TW-1:0]        item_tag_reg, item_tag_next;
    logic [DATA_WIDTH-1:0] item_payload_reg, item_payload_next;

    // List control
    logic [IW-1:0]  scan_idx_reg, scan_idx_next;
    logic [IW-1:0]  slot_reg, slot_next;
    logic [IW-1:0]  walk_reg, walk_next;
    logic [IW-1:0]  walk_link_reg, walk_link_next;
    logic [IW-1:0]  head_reg, head_next;
    logic [IW-1:0]  tail_reg, tail_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [SLOTS-1:0] used_reg, used_next;

    // Result and output register
    tlpq_pkg::status_t     res_status_reg, res_status_next;
    logic [PW-1:0]         res_prio_reg, res_prio_next;
    logic [TW-1:0]         res_tag_reg, res_tag_next;
    logic [DATA_WIDTH-1:0] res_payload_reg, res_payload_next;
    logic                  out_valid_reg, out_valid_next;
    tlpq_pkg::status_t     out_status_reg, out_status_next;
    logic [CW-1:0]         out_count_reg, out_count_next;
    logic [PW-1:0]         out_prio_reg, out_prio_next;
    logic [TW-1:0]         out_tag_reg, out_tag_next;
    logic [DATA_WIDTH-1:0] out_payload_reg, out_payload_next;

    // RAM ports
    logic          p_we, l_we, d_we;
    logic [IW-1:0] l_waddr, pl_raddr;
    logic [IW-1:0] l_wdata;
    logic [PW-1:0] p_rdata;
    logic [IW-1:0] l_rdata;
    logic [DW-1:0] d_rdata;

    // Slot priority, link and message stores
    tlpq_ram #(.WIDTH(PW), .DEPTH(SLOTS)) u_prio_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (slot_reg),
        .wdata (item_prio_reg),
        .raddr (pl_raddr),
        .rdata (p_rdata)
    );

    tlpq_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_link_ram (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .raddr (pl_raddr),
        .rdata (l_rdata)
    );

    tlpq_ram #(.WIDTH(DW), .DEPTH(SLOTS)) u_data_ram (
        .clk   (clk),
        .we    (d_we),
        .waddr (slot_reg),
        .wdata ({item_tag_reg, item_payload_reg}),
        .raddr (head_reg),
        .rdata (d_rdata)
    );

    // Read the head unless the walk fetches a successor
    assign pl_raddr = cmd.rd_next ? walk_link_reg : head_reg;
    assign p_we     = (cmd.op == tlpq_pkg::OP_STORE) || (cmd.op == tlpq_pkg::OP_STORE_FIRST);
    assign d_we     = p_we;

    // Link write port selection
    always_comb
    begin
        l_we    = 1'b0;
        l_waddr = slot_reg;
        l_wdata = '0;
        unique case (cmd.op)
            tlpq_pkg::OP_STORE, tlpq_pkg::OP_STORE_FIRST:
            begin
                l_we = 1'b1;
            end
            tlpq_pkg::OP_APPEND:
            begin
                l_we    = 1'b1;
                l_waddr = tail_reg;
                l_wdata = slot_reg;
            end
            tlpq_pkg::OP_PUSH_HEAD:
            begin
                l_we    = 1'b1;
                l_wdata = head_reg;
            end
            tlpq_pkg::OP_LINK1:
            begin
                l_we    = 1'b1;
                l_wdata = walk_link_reg;
            end
            tlpq_pkg::OP_LINK2:
            begin
                l_we    = 1'b1;
                l_waddr = walk_reg;
                l_wdata = slot_reg;
            end
            default:
            begin
                l_we = 1'b0;
            end
        endcase
    end

    // Status toward the controller
    always_comb
    begin
        stat.item_read      = (item_read_reg == tlpq_pkg::MODE_READ);
        stat.item_prio_bad  = (item_prio_reg == tlpq_pkg::PRIO_INVALID);
        stat.item_prio_zero = (item_prio_reg == tlpq_pkg::PRIO_LOW);
        stat.count_zero     = (count_reg == '0);
        stat.count_full     = (count_reg >= CW'(SLOTS));
        stat.scan_free      = !used_reg[scan_idx_reg];
        stat.scan_last      = (scan_idx_reg == IW'(SLOTS - 1));
        stat.prio_below     = (p_rdata < item_prio_reg);
        stat.walk_at_tail   = (walk_reg == tail_reg);
        stat.out_free       = !out_valid_reg || out_ready;
    end

    // Next values of item, list and result registers
    always_comb
    begin
        item_read_next    = item_read_reg;
        item_prio_next    = item_prio_reg;
        item_tag_next     = item_tag_reg;
        item_payload_next = item_payload_reg;
        scan_idx_next     = scan_idx_reg;
        slot_next         = slot_reg;
        walk_next         = walk_reg;
        walk_link_next    = walk_link_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        count_next        = count_reg;
        used_next         = used_reg;
        res_status_next   = res_status_reg;
        res_prio_next     = res_prio_reg;
        res_tag_next      = res_tag_reg;
        res_payload_next  = res_payload_reg;
        out_status_next   = out_status_reg;
        out_count_next    = out_count_reg;
        out_prio_next     = out_prio_reg;
        out_tag_next      = out_tag_reg;
        out_payload_next  = out_payload_reg;
        out_valid_next    = out_valid_reg && !out_ready;

        // Result status; message fields read as zero unless a read
        if (cmd.res_load)
        begin
            res_status_next  = cmd.res_status;
            res_prio_next    = '0;
            res_tag_next     = '0;
            res_payload_next = '0;
        end

        unique case (cmd.op)
            tlpq_pkg::OP_LATCH:
            begin
                item_read_next    = in_mode;
                item_prio_next    = in_priority_req;
                item_tag_next     = in_producer_tag;
                item_payload_next = in_payload;
            end
            tlpq_pkg::OP_SCAN_CLR:
            begin
                scan_idx_next = '0;
            end
            tlpq_pkg::OP_SCAN_STEP:
            begin
                if (!used_reg[scan_idx_reg])
                begin
                    slot_next = scan_idx_reg;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            tlpq_pkg::OP_STORE:
            begin
                used_next[slot_reg] = 1'b1;
            end
            tlpq_pkg::OP_STORE_FIRST:
            begin
                used_next[slot_reg] = 1'b1;
                head_next           = slot_reg;
                tail_next           = slot_reg;
                count_next          = count_reg + 1'b1;
            end
            tlpq_pkg::OP_APPEND:
            begin
                tail_next  = slot_reg;
                count_next = count_reg + 1'b1;
            end
            tlpq_pkg::OP_PUSH_HEAD:
            begin
                head_next  = slot_reg;
                count_next = count_reg + 1'b1;
            end
            tlpq_pkg::OP_WALK_START:
            begin
                walk_next      = head_reg;
                walk_link_next = l_rdata;
            end
            tlpq_pkg::OP_WALK_ADV:
            begin
                walk_next      = walk_link_reg;
                walk_link_next = l_rdata;
            end
            tlpq_pkg::OP_LINK1:
            begin
                if (walk_reg == tail_reg)
                begin
                    tail_next = slot_reg;
                end
            end
            tlpq_pkg::OP_LINK2:
            begin
                count_next = count_reg + 1'b1;
            end
            tlpq_pkg::OP_POP:
            begin
                used_next[head_reg] = 1'b0;
                head_next           = l_rdata;
                count_next          = count_reg - 1'b1;
                res_prio_next       = p_rdata;
                res_tag_next        = d_rdata[DW-1 -: TW];
                res_payload_next    = d_rdata[DATA_WIDTH-1:0];
            end
            tlpq_pkg::OP_OUT_LOAD:
            begin
                out_valid_next   = 1'b1;
                out_status_next  = res_status_reg;
                out_count_next   = count_reg;
                out_prio_next    = res_prio_reg;
                out_tag_next     = res_tag_reg;
                out_payload_next = res_payload_reg;
            end
            default:
            begin
                scan_idx_next = scan_idx_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg  <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            scan_idx_reg  <= scan_idx_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_read_reg    <= item_read_next;
        item_prio_reg    <= item_prio_next;
        item_tag_reg     <= item_tag_next;
        item_payload_reg <= item_payload_next;
        slot_reg         <= slot_next;
        walk_reg         <= walk_next;
        walk_link_reg    <= walk_link_next;
        res_status_reg   <= res_status_next;
        res_prio_reg     <= res_prio_next;
        res_tag_reg      <= res_tag_next;
        res_payload_reg  <= res_payload_next;
        out_status_reg   <= out_status_next;
        out_count_reg    <= out_count_next;
        out_prio_reg     <= out_prio_next;
        out_tag_reg      <= out_tag_next;
        out_payload_reg  <= out_payload_next;
    end

    assign out_valid        = out_valid_reg;
    assign out_status       = out_status_reg;
    assign out_queued_count = out_count_reg;
    assign out_priority     = out_prio_reg;
    assign out_producer_tag = out_tag_reg;
    assign out_payload      = out_payload_reg;

    // Checks
    `TLPQ_ASSERT_NOW(a_count_range, 1'b1, count_reg <= CW'(SLOTS))
    `TLPQ_ASSERT_NOW(a_used_matches_count, cmd.op == tlpq_pkg::OP_OUT_LOAD, $countones(used_reg) == count_reg)
    `TLPQ_ASSERT_NOW(a_store_free_slot, p_we, !used_reg[slot_reg])
    `TLPQ_ASSERT_NEXT(a_pop_count, cmd.op == tlpq_pkg::OP_POP, count_reg == $past(count_reg) - CW'(1))

endmodule

>>> hw/rtl/three_level_priority_queue_top.sv
// Three-level priority message queue: stream in, one result beat per input beat.
// From accept to result valid: a read or a rejected send goes straight to the result; a send
// scans for the lowest free slot, stores, then appends at level 0, pushes at the head, or walks
// the list link by link and splices the item in; the scan and the walk set the longest case.
// A new beat is taken once the last result is loaded; one waiting result does not block it.
// Reset: rst_n asynchronous, active low; clears used bits and pointers, no clearing pass.
`timescale 1ns / 1ps

module three_level_priority_queue_top #(
    parameter int SLOTS      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // priority_req[1:0], producer_tag[9:2], payload, zero fill to bytes
    input  logic [((tlpq_pkg::PRIO_W + tlpq_pkg::TAG_W + DATA_WIDTH + 7) / 8) * 8 - 1:0]
                 s_axis_tdata,
    // mode
    input  logic s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // queued_count, out_priority, out_producer_tag, out_payload, zero fill to bytes
    output logic [(($clog2(SLOTS + 1) + tlpq_pkg::PRIO_W + tlpq_pkg::TAG_W + DATA_WIDTH + 7)
                   / 8) * 8 - 1:0] m_axis_tdata,
    // status
    output logic [2:0] m_axis_tuser
);

    localparam int CW    = $clog2(SLOTS + 1);
    localparam int PW    = tlpq_pkg::PRIO_W;
    localparam int TW    = tlpq_pkg::TAG_W;
    localparam int OUT_W = ((CW + PW + TW + DATA_WIDTH + 7) / 8) * 8;

    tlpq_pkg::cmd_t    cmd;
    tlpq_pkg::stat_t   stat;
    tlpq_pkg::status_t out_status;
    logic [CW-1:0]         out_count;
    logic [PW-1:0]         out_prio;
    logic [TW-1:0]         out_tag;
    logic [DATA_WIDTH-1:0] out_payload;

    tlpq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tlpq_dp #(
        .SLOTS      (SLOTS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .in_mode          (s_axis_tuser),
        .in_priority_req  (s_axis_tdata[PW-1:0]),
        .in_producer_tag  (s_axis_tdata[PW +: TW]),
        .in_payload       (s_axis_tdata[PW + TW +: DATA_WIDTH]),
        .out_valid        (m_axis_tvalid),
        .out_ready        (m_axis_tready),
        .out_status       (out_status),
        .out_queued_count (out_count),
        .out_priority     (out_prio),
        .out_producer_tag (out_tag),
        .out_payload      (out_payload)
    );

    // Pack the result beat
    assign m_axis_tdata = OUT_W'({out_payload, out_tag, out_prio, out_count});
    assign m_axis_tuser = out_status;

endmodule
